/* design/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, quiet during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

/* design/prts_pkg.sv */
package prts_pkg;

   localparam int DATA_W     = 32;
   localparam int SIZE_W     = 25;
   localparam int ACT_W      = 3;
   localparam int SLOT_OUT_W = 4;
   localparam int CSR_IDX_W  = 1;

   typedef enum logic [1:0] {
      ST_EMPTY    = 2'd0,
      ST_RUNNABLE = 2'd1,
      ST_BLOCKED  = 2'd2,
      ST_ZOMBIE   = 2'd3
   } slot_state_type;

   localparam logic [ACT_W-1:0] ACT_GETPID = 3'd0;
   localparam logic [ACT_W-1:0] ACT_FORK   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_YIELD  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_EXIT   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_WAIT   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_STACK_BASE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STACK_SIZE = 1'b1;

   localparam logic [DATA_W-1:0] STACK_BASE_RESET = 32'h0028_0000;
   localparam logic [SIZE_W-1:0] STACK_SIZE_RESET = 25'h004_0000;
   localparam logic [DATA_W-1:0] EAX_FAIL         = 32'hFFFF_FFFF;

endpackage

/* design/prts_if.sv */
interface prts_req_if;
   logic                               valid;
   logic                               ready;
   logic [prts_pkg::ACT_W-1:0]         action;
   logic signed [prts_pkg::DATA_W-1:0] caller_eax;
   logic [prts_pkg::DATA_W-1:0]        caller_sp;

   modport source (output valid, action, caller_eax, caller_sp, input ready);
   modport sink   (input valid, action, caller_eax, caller_sp, output ready);
endinterface

interface prts_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [prts_pkg::SLOT_OUT_W-1:0]    next_slot;
   logic signed [prts_pkg::DATA_W-1:0] next_eax;
   logic                               copy_request;
   logic [prts_pkg::DATA_W-1:0]        copy_source;
   logic [prts_pkg::DATA_W-1:0]        copy_dest;
   logic [prts_pkg::SIZE_W-1:0]        copy_length;
   logic                               halted;

   modport source (output valid, next_slot, next_eax, copy_request, copy_source,
                   copy_dest, copy_length, halted, input ready);
   modport sink   (input valid, next_slot, next_eax, copy_request, copy_source,
                   copy_dest, copy_length, halted, output ready);
endinterface

/* design/process_table_round_robin_scheduler_core.sv */
// The slot scans (free slot, runnable slot, waiter wake-up) visit one slot per cycle.
// One request in flight; a new one is taken while the previous result beat waits.
// Reset is synchronous: slot 1 runnable and running, all other slots empty, not
// halted, stack registers at defaults. Stores clear through valid bits, no sweep.
module process_table_round_robin_scheduler_core #(
   parameter int SLOT_COUNT = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   prts_req_if.sink                        req_bus,
   prts_rsp_if.source                      rsp_bus,
   input  logic                            csr_we,
   input  logic [prts_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [prts_pkg::DATA_W-1:0]     csr_wdata
);

   localparam int SW = $clog2(SLOT_COUNT);
   localparam int CW = $clog2(SLOT_COUNT + 1);
   localparam int MW = SW + prts_pkg::SIZE_W;
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);
   localparam logic [CW-1:0] SCAN_END  = CW'(SLOT_COUNT);

   // Sequencer states. Fork runs through the shared multiply/add/subtract
   // path; exit walks the caller's waiter mask; scans share one status port.
   typedef enum logic [4:0] {
      S_IDLE,
      S_FORK_SCAN,
      S_MUL_P,
      S_ADD_P,
      S_MUL_C,
      S_ADD_C,
      S_LEN,
      S_CLAMP,
      S_SRC,
      S_DST,
      S_EXIT_WAKE,
      S_EXIT_END,
      S_WAIT_CHK,
      S_WAIT_ZWR,
      S_WAIT_MWR,
      S_SCHED,
      S_RD_OUT,
      S_OUT
   } state_type;

   // ---------------------------------------------------------------- config
   logic [prts_pkg::DATA_W-1:0] stack_base_ff;
   logic [prts_pkg::SIZE_W-1:0] stack_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_base_ff <= prts_pkg::STACK_BASE_RESET;
         stack_size_ff <= prts_pkg::STACK_SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            prts_pkg::CSR_STACK_BASE: stack_base_ff <= csr_wdata;
            prts_pkg::CSR_STACK_SIZE: stack_size_ff <= csr_wdata[prts_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- state
   state_type                   state_ff;
   logic                        halt_ff;
   logic [SW-1:0]               running_ff;
   prts_pkg::slot_state_type    status_ff [SLOT_COUNT];
   logic [SW-1:0]               scan_ff;     // round-robin scan pointer
   logic [CW-1:0]               cnt_ff;      // slots visited so far
   logic [SW-1:0]               idx_ff;      // waiter walk index
   logic                        any_ff;      // exit woke at least one waiter
   logic [SW-1:0]               child_ff;
   logic [prts_pkg::DATA_W-1:0] eax_ff;
   logic [prts_pkg::DATA_W-1:0] sp_ff;
   logic [MW-1:0]               mul_ff;
   logic [prts_pkg::DATA_W-1:0] ptop_ff;
   logic [prts_pkg::DATA_W-1:0] ctop_ff;
   logic [prts_pkg::DATA_W-1:0] len_ff;
   logic [prts_pkg::DATA_W-1:0] cp_src_ff;
   logic [prts_pkg::DATA_W-1:0] cp_dst_ff;
   logic                        cp_req_ff;

   // result beat register
   logic                            rsp_valid_ff;
   logic [prts_pkg::SLOT_OUT_W-1:0] rsp_slot_ff;
   logic [prts_pkg::DATA_W-1:0]     rsp_eax_ff;
   logic                            rsp_req_ff;
   logic [prts_pkg::DATA_W-1:0]     rsp_src_ff;
   logic [prts_pkg::DATA_W-1:0]     rsp_dst_ff;
   logic [prts_pkg::SIZE_W-1:0]     rsp_len_ff;
   logic                            rsp_halt_ff;

   // ---------------------------------------------------------------- datapath
   logic                        req_fire;
   logic                        rsp_free;
   logic [SW-1:0]               tgt;
   logic [SW-1:0]               st_addr;
   prts_pkg::slot_state_type    st_rd;
   logic [SW-1:0]               scan_next;
   logic [SW-1:0]               run_next;
   logic                        scan_done;
   logic                        wait_bad;
   logic [SW-1:0]               mul_slot;
   logic [SW-1:0]               rd_addr;
   logic [SLOT_COUNT-1:0]       cur_bit;

   logic                        sv_we;
   logic [SW-1:0]               sv_addr;
   logic [prts_pkg::DATA_W-1:0] sv_wdata;
   logic [prts_pkg::DATA_W-1:0] sv_rd;

   logic                        ex_we;
   logic [prts_pkg::DATA_W-1:0] ex_rd;

   logic                        mk_we;
   logic [SW-1:0]               mk_addr;
   logic [SLOT_COUNT-1:0]       mk_wdata;
   logic [SLOT_COUNT-1:0]       mk_rd;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   assign tgt       = eax_ff[SW-1:0];
   assign st_addr   = (state_ff == S_WAIT_CHK) ? tgt : scan_ff;
   assign st_rd     = status_ff[st_addr];
   assign scan_next = (scan_ff == LAST_SLOT) ? '0 : scan_ff + 1'b1;
   assign run_next  = (running_ff == LAST_SLOT) ? '0 : running_ff + 1'b1;
   assign scan_done = (cnt_ff == SCAN_END);
   assign mul_slot  = (state_ff == S_MUL_P) ? running_ff : child_ff;
   assign rd_addr   = (state_ff == S_WAIT_CHK) ? tgt : running_ff;
   assign cur_bit   = SLOT_COUNT'(1) << running_ff;

   // wait target that yields -1: negative, slot 0, out of range, self or empty
   assign wait_bad = eax_ff[prts_pkg::DATA_W-1] || (eax_ff == '0)
                     || (eax_ff >= prts_pkg::DATA_W'(SLOT_COUNT))
                     || (eax_ff == prts_pkg::DATA_W'(running_ff))
                     || (st_rd == prts_pkg::ST_EMPTY);

   // saved-eax write port
   always_comb begin
      sv_we    = 1'b0;
      sv_addr  = running_ff;
      sv_wdata = eax_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && !halt_ff) begin
               sv_we    = 1'b1;
               sv_wdata = (req_bus.action == prts_pkg::ACT_GETPID)
                          ? prts_pkg::DATA_W'(running_ff) : req_bus.caller_eax;
            end
         end
         S_FORK_SCAN: begin
            if (!(scan_ff != '0 && st_rd == prts_pkg::ST_EMPTY) && scan_done) begin
               sv_we    = 1'b1;
               sv_wdata = prts_pkg::EAX_FAIL;
            end
         end
         S_MUL_P: begin
            sv_we    = 1'b1;
            sv_addr  = child_ff;
            sv_wdata = '0;
         end
         S_ADD_P: begin
            sv_we    = 1'b1;
            sv_wdata = prts_pkg::DATA_W'(child_ff);
         end
         S_EXIT_WAKE: begin
            if (mk_rd[idx_ff]) begin
               sv_we   = 1'b1;
               sv_addr = idx_ff;
            end
         end
         S_WAIT_CHK: begin
            if (wait_bad) begin
               sv_we    = 1'b1;
               sv_wdata = prts_pkg::EAX_FAIL;
            end
         end
         S_WAIT_ZWR: begin
            sv_we    = 1'b1;
            sv_wdata = ex_rd;
         end
         default: ;
      endcase
   end

   assign ex_we = req_fire && !halt_ff && (req_bus.action == prts_pkg::ACT_EXIT);

   // waiter-mask write port
   always_comb begin
      mk_we    = 1'b0;
      mk_addr  = running_ff;
      mk_wdata = '0;
      case (state_ff)
         S_MUL_P: begin
            mk_we   = 1'b1;
            mk_addr = child_ff;
         end
         S_EXIT_END: mk_we = any_ff;
         S_WAIT_MWR: begin
            mk_we    = 1'b1;
            mk_addr  = tgt;
            mk_wdata = mk_rd | cur_bit;
         end
         default: ;
      endcase
   end

   prts_slot_ram #(.DEPTH(SLOT_COUNT), .WIDTH(prts_pkg::DATA_W)) u_saved (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (sv_we),
      .wr_addr(sv_addr),
      .wr_data(sv_wdata),
      .rd_addr(rd_addr),
      .rd_data(sv_rd)
   );

   prts_slot_ram #(.DEPTH(SLOT_COUNT), .WIDTH(prts_pkg::DATA_W)) u_exit (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (ex_we),
      .wr_addr(running_ff),
      .wr_data(req_bus.caller_eax),
      .rd_addr(rd_addr),
      .rd_data(ex_rd)
   );

   prts_slot_ram #(.DEPTH(SLOT_COUNT), .WIDTH(SLOT_COUNT)) u_mask (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (mk_we),
      .wr_addr(mk_addr),
      .wr_data(mk_wdata),
      .rd_addr(rd_addr),
      .rd_data(mk_rd)
   );

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         halt_ff      <= 1'b0;
         running_ff   <= SW'(1);
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < SLOT_COUNT; s++) begin
            status_ff[s] <= (s == 1) ? prts_pkg::ST_RUNNABLE : prts_pkg::ST_EMPTY;
         end
      end else begin
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  eax_ff    <= req_bus.caller_eax;
                  sp_ff     <= req_bus.caller_sp;
                  cp_req_ff <= 1'b0;
                  cp_src_ff <= '0;
                  cp_dst_ff <= '0;
                  len_ff    <= '0;
                  scan_ff   <= run_next;
                  cnt_ff    <= CW'(1);
                  idx_ff    <= '0;
                  any_ff    <= 1'b0;
                  if (halt_ff) begin
                     state_ff <= S_OUT;
                  end else begin
                     unique case (req_bus.action)
                        prts_pkg::ACT_GETPID: state_ff <= S_RD_OUT;
                        prts_pkg::ACT_FORK:   state_ff <= S_FORK_SCAN;
                        prts_pkg::ACT_YIELD:  state_ff <= S_SCHED;
                        prts_pkg::ACT_EXIT: begin
                           status_ff[running_ff] <= prts_pkg::ST_ZOMBIE;
                           state_ff <= S_EXIT_WAKE;
                        end
                        prts_pkg::ACT_WAIT:   state_ff <= S_WAIT_CHK;
                        default: begin
                           halt_ff  <= 1'b1;
                           state_ff <= S_OUT;
                        end
                     endcase
                  end
               end
            end

            S_FORK_SCAN: begin
               if (scan_ff != '0 && st_rd == prts_pkg::ST_EMPTY) begin
                  child_ff <= scan_ff;
                  state_ff <= S_MUL_P;
               end else if (scan_done) begin
                  state_ff <= S_RD_OUT;
               end else begin
                  scan_ff <= scan_next;
                  cnt_ff  <= cnt_ff + 1'b1;
               end
            end

            // stack top = base + slot * size, parent then child
            S_MUL_P: begin
               status_ff[child_ff] <= prts_pkg::ST_RUNNABLE;
               mul_ff   <= mul_slot * stack_size_ff;
               state_ff <= S_ADD_P;
            end
            S_ADD_P: begin
               ptop_ff  <= stack_base_ff + prts_pkg::DATA_W'(mul_ff);
               state_ff <= S_MUL_C;
            end
            S_MUL_C: begin
               mul_ff   <= mul_slot * stack_size_ff;
               state_ff <= S_ADD_C;
            end
            S_ADD_C: begin
               ctop_ff  <= stack_base_ff + prts_pkg::DATA_W'(mul_ff);
               state_ff <= S_LEN;
            end
            S_LEN: begin
               len_ff   <= (sp_ff > ptop_ff) ? '0 : ptop_ff - sp_ff;
               state_ff <= S_CLAMP;
            end
            S_CLAMP: begin
               if (len_ff > prts_pkg::DATA_W'(stack_size_ff)) begin
                  len_ff <= prts_pkg::DATA_W'(stack_size_ff);
               end
               state_ff <= S_SRC;
            end
            S_SRC: begin
               cp_src_ff <= ptop_ff - len_ff;
               state_ff  <= S_DST;
            end
            S_DST: begin
               cp_dst_ff <= ctop_ff - len_ff;
               cp_req_ff <= 1'b1;
               state_ff  <= S_RD_OUT;
            end

            // mask read data of the caller is held since the accept edge
            S_EXIT_WAKE: begin
               if (mk_rd[idx_ff]) begin
                  status_ff[idx_ff] <= prts_pkg::ST_RUNNABLE;
                  any_ff <= 1'b1;
               end
               if (idx_ff == LAST_SLOT) begin
                  state_ff <= S_EXIT_END;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_EXIT_END: begin
               if (any_ff) begin
                  status_ff[running_ff] <= prts_pkg::ST_EMPTY;
               end
               state_ff <= S_SCHED;
            end

            S_WAIT_CHK: begin
               if (wait_bad) begin
                  state_ff <= S_SCHED;
               end else if (st_rd == prts_pkg::ST_ZOMBIE) begin
                  status_ff[tgt] <= prts_pkg::ST_EMPTY;
                  state_ff <= S_WAIT_ZWR;
               end else begin
                  status_ff[running_ff] <= prts_pkg::ST_BLOCKED;
                  state_ff <= S_WAIT_MWR;
               end
            end
            S_WAIT_ZWR: state_ff <= S_SCHED;
            S_WAIT_MWR: state_ff <= S_SCHED;

            // round robin: slots after the running one, the running one last
            S_SCHED: begin
               if (st_rd == prts_pkg::ST_RUNNABLE) begin
                  running_ff <= scan_ff;
                  state_ff   <= S_RD_OUT;
               end else if (scan_done) begin
                  halt_ff  <= 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  scan_ff <= scan_next;
                  cnt_ff  <= cnt_ff + 1'b1;
               end
            end

            S_RD_OUT: state_ff <= S_OUT;

            S_OUT: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_slot_ff  <= prts_pkg::SLOT_OUT_W'(running_ff);
                  rsp_eax_ff   <= halt_ff ? '0 : sv_rd;
                  rsp_req_ff   <= cp_req_ff;
                  rsp_src_ff   <= cp_src_ff;
                  rsp_dst_ff   <= cp_dst_ff;
                  rsp_len_ff   <= len_ff[prts_pkg::SIZE_W-1:0];
                  rsp_halt_ff  <= halt_ff;
                  state_ff     <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.next_slot    = rsp_slot_ff;
   assign rsp_bus.next_eax     = rsp_eax_ff;
   assign rsp_bus.copy_request = rsp_req_ff;
   assign rsp_bus.copy_source  = rsp_src_ff;
   assign rsp_bus.copy_dest    = rsp_dst_ff;
   assign rsp_bus.copy_length  = rsp_len_ff;
   assign rsp_bus.halted       = rsp_halt_ff;

endmodule

/* design/prts_slot_ram.sv */
// Per-slot store with one write and one registered read port.
// Entries never written since reset read as zero.
module prts_slot_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   assign rd_data = rd_q_ff;

endmodule

/* design/prts_checker.sv */
`include "assert_macros.svh"

module prts_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [prts_pkg::DATA_W-1:0] rsp_next_eax,
   input logic                              rsp_copy_request,
   input logic [prts_pkg::DATA_W-1:0]       rsp_copy_source,
   input logic [prts_pkg::DATA_W-1:0]       rsp_copy_dest,
   input logic [prts_pkg::SIZE_W-1:0]       rsp_copy_length,
   input logic                              rsp_halted
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_IMPLY(a_halt_quiet, clock, reset, rsp_valid && rsp_halted, (rsp_next_eax == 0) && !rsp_copy_request)
   `ASSERT_IMPLY(a_copy_idle_zero, clock, reset, rsp_valid && !rsp_copy_request, (rsp_copy_source == 0) && (rsp_copy_dest == 0) && (rsp_copy_length == 0))
   `ASSERT_IMPLY(a_fork_child_pid, clock, reset, rsp_valid && rsp_copy_request, !rsp_next_eax[31] && (rsp_next_eax != 0) && !rsp_halted)

endmodule

bind process_table_round_robin_scheduler_core prts_checker u_prts_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_next_eax    (rsp_bus.next_eax),
   .rsp_copy_request(rsp_bus.copy_request),
   .rsp_copy_source (rsp_bus.copy_source),
   .rsp_copy_dest   (rsp_bus.copy_dest),
   .rsp_copy_length (rsp_bus.copy_length),
   .rsp_halted      (rsp_bus.halted)
);

/* tb/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import prts_pkg::*;

   localparam int NSLOT = 16;
   // Longest stretch with no beat on either side before the run is declared hung.
   // Worst legit case: a full receiver hold-off plus one exit scan.
   localparam int WATCHDOG_LIMIT = 5000;
   // Receiver hold-off length, long enough to back the block up into its input.
   localparam int HOLD_CYCLES = 400;

   // One system call as offered on the request channel.
   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [DATA_W-1:0] caller_eax;
      logic [DATA_W-1:0] caller_sp;
   } call_t;

   // One dispatch decision as returned on the result channel.
   typedef struct packed {
      logic [SLOT_OUT_W-1:0] next_slot;
      logic [DATA_W-1:0]     next_eax;
      logic                  copy_request;
      logic [DATA_W-1:0]     copy_source;
      logic [DATA_W-1:0]     copy_dest;
      logic [SIZE_W-1:0]     copy_length;
      logic                  halted;
   } dispatch_t;

   // Whole process table plus the stack region registers.
   typedef struct packed {
      slot_state_type [NSLOT-1:0]    status;
      logic [NSLOT-1:0][DATA_W-1:0]  exit_code;
      logic [NSLOT-1:0][DATA_W-1:0]  saved_eax;
      logic [NSLOT-1:0][NSLOT-1:0]   waiters;
      logic [SLOT_OUT_W-1:0]         running;
      logic                          halt;
      logic [DATA_W-1:0]             stack_base;
      logic [SIZE_W-1:0]             stack_size;
   } ptable_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // TB-side copies of every DUT input, known from time zero.
   logic                 req_valid  = 1'b0;
   logic [ACT_W-1:0]     req_action = '0;
   logic [DATA_W-1:0]    req_eax    = '0;
   logic [DATA_W-1:0]    req_sp     = '0;
   logic                 rsp_ready  = 1'b0;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [DATA_W-1:0]    csr_wdata  = '0;

   prts_req_if req_bus ();
   prts_rsp_if rsp_bus ();

   assign req_bus.valid      = req_valid;
   assign req_bus.action     = req_action;
   assign req_bus.caller_eax = req_eax;
   assign req_bus.caller_sp  = req_sp;
   assign rsp_bus.ready      = rsp_ready;

   process_table_round_robin_scheduler_core #(.SLOT_COUNT(NSLOT)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // model: table as seen by accepted beats (drives the checks).
   // plan:  table as it will be once every queued call is taken (drives generation).
   ptable_t     model;
   ptable_t     plan;
   call_t       syscall_queue[$];
   dispatch_t   expected_dispatch[$];
   call_t       offered;
   int          mismatches = 0;

   // ---------------------------------------------------------------------
   // Process table behavior
   // ---------------------------------------------------------------------

   function automatic ptable_t boot_state();
      ptable_t st;
      st = '0;
      st.status[1]  = ST_RUNNABLE;
      st.running    = 4'd1;
      st.stack_base = STACK_BASE_RESET;
      st.stack_size = STACK_SIZE_RESET;
      return st;
   endfunction

   // Top of a slot's stack region, wraps at 2^32.
   function automatic logic [DATA_W-1:0] stack_top(input ptable_t st, input int slot);
      return st.stack_base + 32'(slot) * {7'd0, st.stack_size};
   endfunction

   // Apply one system call from the running slot; returns the dispatch it causes.
   function automatic dispatch_t run_syscall(inout ptable_t st, input call_t rq);
      dispatch_t   rs;
      logic [31:0] eax, ptop, ctop, len, size32;
      logic        found, resched;
      int          cur, child, sl, tgt, i;
      rs = '0;
      cur = st.running;
      if (st.halt) begin
         // halted: call ignored, report where we stopped
         rs.next_slot = st.running;
         rs.halted    = 1'b1;
         return rs;
      end
      eax = rq.caller_eax;
      size32 = {7'd0, st.stack_size};
      resched = 1'b0;
      st.saved_eax[cur] = eax;
      case (rq.action)
         ACT_GETPID: st.saved_eax[cur] = 32'(cur);
         ACT_FORK: begin
            found = 1'b0;
            child = 0;
            for (i = 1; i <= NSLOT; i++) begin
               sl = (cur + i) % NSLOT;
               if (!found && sl != 0 && st.status[sl] == ST_EMPTY) begin
                  child = sl;
                  found = 1'b1;
               end
            end
            if (found) begin
               ptop = stack_top(st, cur);
               ctop = stack_top(st, child);
               // sp above the top gives nothing to copy; a deep sp is capped
               len = (rq.caller_sp > ptop) ? 32'd0 : ptop - rq.caller_sp;
               if (len > size32) len = size32;
               st.status[child]    = ST_RUNNABLE;
               st.saved_eax[child] = '0;
               st.waiters[child]   = '0;
               st.saved_eax[cur]   = 32'(child);
               rs.copy_request = 1'b1;
               rs.copy_source  = ptop - len;
               rs.copy_dest    = ctop - len;
               rs.copy_length  = len[SIZE_W-1:0];
            end else begin
               st.saved_eax[cur] = EAX_FAIL;
            end
         end
         ACT_YIELD: resched = 1'b1;
         ACT_EXIT: begin
            st.status[cur]    = ST_ZOMBIE;
            st.exit_code[cur] = eax;
            // waiters collect the code at once, so no zombie is left behind
            for (i = 0; i < NSLOT; i++) begin
               if (st.waiters[cur][i]) begin
                  st.status[cur]     = ST_EMPTY;
                  st.status[i]       = ST_RUNNABLE;
                  st.saved_eax[i]    = eax;
                  st.waiters[cur][i] = 1'b0;
               end
            end
            resched = 1'b1;
         end
         ACT_WAIT: begin
            tgt = eax[3:0];
            if (eax[31] || eax == 0 || eax >= NSLOT || tgt == cur
                || st.status[tgt] == ST_EMPTY) begin
               st.saved_eax[cur] = EAX_FAIL;
            end else if (st.status[tgt] == ST_ZOMBIE) begin
               st.status[tgt]    = ST_EMPTY;
               st.saved_eax[cur] = st.exit_code[tgt];
            end else begin
               st.status[cur]       = ST_BLOCKED;
               st.waiters[tgt][cur] = 1'b1;
            end
            resched = 1'b1;
         end
         default: st.halt = 1'b1;
      endcase

      if (resched) begin
         // scan starts after the running slot and ends on it
         found = 1'b0;
         for (i = 1; i <= NSLOT; i++) begin
            sl = (cur + i) % NSLOT;
            if (!found && st.status[sl] == ST_RUNNABLE) begin
               st.running = sl;
               found = 1'b1;
            end
         end
         if (!found) st.halt = 1'b1;
      end

      rs.next_slot = st.running;
      if (st.halt) rs.halted = 1'b1;
      else rs.next_eax = st.saved_eax[st.running];
      return rs;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   function automatic call_t make_call(input logic [ACT_W-1:0] act,
                                       input logic [DATA_W-1:0] eax,
                                       input logic [DATA_W-1:0] sp);
      call_t rq;
      rq.action     = act;
      rq.caller_eax = eax;
      rq.caller_sp  = sp;
      return rq;
   endfunction

   // Random call that keeps at least one slot runnable, so the table stays live.
   function automatic call_t pick_call(input ptable_t st, input int fork_pct);
      call_t       rq;
      logic [31:0] ptop, size32;
      int          cur, others, roll, tgt, sl, i;
      logic        found;
      cur = st.running;
      size32 = {7'd0, st.stack_size};
      ptop = stack_top(st, cur);
      others = 0;
      for (i = 0; i < NSLOT; i++)
         if (i != cur && st.status[i] == ST_RUNNABLE) others++;

      rq.caller_eax = $urandom;
      case ($urandom_range(9))
         0: rq.caller_sp = $urandom;
         1: rq.caller_sp = ptop + $urandom_range(1, 64);           // above the top
         2: rq.caller_sp = ptop - size32 - $urandom_range(0, 64);  // deeper than region
         3: rq.caller_sp = ptop;                                   // empty stack
         default: rq.caller_sp = ptop - $urandom_range(0, size32);
      endcase

      roll = $urandom_range(99);
      if (roll < fork_pct) rq.action = ACT_FORK;
      else if (roll < fork_pct + 8) rq.action = ACT_GETPID;
      else if (roll < fork_pct + 25) rq.action = ACT_YIELD;
      else if (roll < fork_pct + 45) rq.action = ACT_EXIT;
      else rq.action = ACT_WAIT;

      if (rq.action == ACT_WAIT) begin
         case ($urandom_range(7))
            0: rq.caller_eax = {1'b1, 31'($urandom)};
            1: rq.caller_eax = 32'(cur);
            2: rq.caller_eax = $urandom_range(NSLOT - 1);
            3: rq.caller_eax = $urandom_range(NSLOT, 1000);
            default: begin
               // a live target: zombie to reap, or someone to block on
               sl = $urandom_range(1, NSLOT - 1);
               found = 1'b0;
               for (i = 0; i < NSLOT; i++) begin
                  tgt = (sl + i) % NSLOT;
                  if (!found && tgt != 0 && tgt != cur && st.status[tgt] != ST_EMPTY) begin
                     rq.caller_eax = 32'(tgt);
                     found = 1'b1;
                  end
               end
            end
         endcase
         tgt = rq.caller_eax[3:0];
         // blocking the last runnable slot would halt the table
         if (rq.caller_eax < NSLOT && tgt != 0 && tgt != cur && others == 0
             && st.status[tgt] == ST_BLOCKED)
            rq.action = ACT_YIELD;
      end
      if (rq.action == ACT_EXIT && others == 0 && st.waiters[cur] == '0)
         rq.action = ACT_FORK;
      return rq;
   endfunction

   task automatic queue_call(input call_t rq);
      void'(run_syscall(plan, rq));
      syscall_queue.push_back(rq);
   endtask

   // Everything sent, taken and answered.
   task automatic wait_idle();
      do @(negedge clock);
      while (syscall_queue.size() != 0 || req_valid || expected_dispatch.size() != 0);
   endtask

   task automatic run_phase(input int count, input int fork_pct);
      @(negedge clock);
      repeat (count) queue_call(pick_call(plan, fork_pct));
      wait_idle();
   endtask

   // Only called with the block idle.
   task automatic set_stack_region(input logic [DATA_W-1:0] base,
                                   input logic [SIZE_W-1:0] size);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_STACK_BASE;
      csr_wdata <= base;
      @(posedge clock);
      csr_index <= CSR_STACK_SIZE;
      csr_wdata <= {7'd0, size};
      @(posedge clock);
      csr_we <= 1'b0;
      model.stack_base = base;
      model.stack_size = size;
      plan.stack_base  = base;
      plan.stack_size  = size;
   endtask

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   function automatic void report_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %h actual %h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   function automatic void compare_dispatch(input dispatch_t want, input dispatch_t got);
      report_field("next_slot", 32'(want.next_slot), 32'(got.next_slot));
      report_field("next_eax", want.next_eax, got.next_eax);
      report_field("copy_request", 32'(want.copy_request), 32'(got.copy_request));
      report_field("copy_source", want.copy_source, got.copy_source);
      report_field("copy_dest", want.copy_dest, got.copy_dest);
      report_field("copy_length", 32'(want.copy_length), 32'(got.copy_length));
      report_field("halted", 32'(want.halted), 32'(got.halted));
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: bursts of random length, random gaps in between.
   // The predictor runs on the beat, so the model follows the DUT exactly.
   // ---------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_bus.ready)
            expected_dispatch.push_back(run_syscall(model, offered));
         // free to present the next beat?
         if (!req_valid || req_bus.ready) begin
            if (gap_left > 0 || syscall_queue.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               offered = syscall_queue.pop_front();
               req_valid  <= 1'b1;
               req_action <= offered.action;
               req_eax    <= offered.caller_eax;
               req_sp     <= offered.caller_sp;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  // about a quarter of bursts run straight into the next one
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: own rotating stall pattern, plus two long hold-offs to back
   // the block up into its request side.
   // ---------------------------------------------------------------------
   logic [7:0] stall_pattern = 8'hFF;
   int         pattern_age   = 0;
   int         hold_left     = 0;
   int         results_seen  = 0;

   always @(posedge clock) begin
      dispatch_t got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_ready) begin
            got.next_slot    = rsp_bus.next_slot;
            got.next_eax     = rsp_bus.next_eax;
            got.copy_request = rsp_bus.copy_request;
            got.copy_source  = rsp_bus.copy_source;
            got.copy_dest    = rsp_bus.copy_dest;
            got.copy_length  = rsp_bus.copy_length;
            got.halted       = rsp_bus.halted;
            if (expected_dispatch.size() == 0) begin
               $display("%0t unexpected beat: expected none actual %h", $time, got);
               mismatches++;
            end else begin
               compare_dispatch(expected_dispatch.pop_front(), got);
            end
            results_seen++;
            if (results_seen == 150 || results_seen == 800) hold_left = HOLD_CYCLES;
         end
         pattern_age++;
         if (pattern_age == 50) begin
            pattern_age = 0;
            stall_pattern = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
         end
         stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= stall_pattern[0];
         end
      end
   end

   // Watchdog: too long with no beat on either channel means a hang.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_bus.ready) || (rsp_bus.valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      model = boot_state();
      plan  = model;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opener, default stack region (slot 1 top = 0x2C0000).
      queue_call(make_call(ACT_GETPID, 32'h8000_0000, 32'hFFFF_FFFF));
      queue_call(make_call(ACT_FORK, 32'h7FFF_FFFF, 32'h002B_FF00)); // short copy
      queue_call(make_call(ACT_FORK, 32'h0, 32'h002C_0005));         // sp above top
      queue_call(make_call(ACT_FORK, $urandom, 32'h0));              // capped copy
      queue_call(make_call(ACT_WAIT, 32'h8000_0000, $urandom));      // negative target
      queue_call(make_call(ACT_WAIT, 32'h0, $urandom));              // slot 0
      queue_call(make_call(ACT_WAIT, 32'd16, $urandom));             // past the table
      queue_call(make_call(ACT_WAIT, 32'd4, $urandom));              // slot 4 on itself
      queue_call(make_call(ACT_WAIT, 32'd9, $urandom));              // empty slot
      queue_call(make_call(ACT_EXIT, 32'h7FFF_FFFF, $urandom));      // slot 2 -> zombie
      queue_call(make_call(ACT_WAIT, 32'd2, $urandom));              // reap zombie
      queue_call(make_call(ACT_WAIT, 32'd3, $urandom));              // 4 blocks on 3
      queue_call(make_call(ACT_YIELD, $urandom, $urandom));
      queue_call(make_call(ACT_EXIT, 32'hFFFF_FFFE, $urandom));      // 3 exits, wakes 4
      queue_call(make_call(ACT_WAIT, 32'd3, $urandom));              // 3 already freed
      queue_call(make_call(ACT_FORK, $urandom, 32'hFFFF_FFFF));

      // Random phases; each ends with a full drain (sender pause).
      run_phase(260, 30);
      set_stack_region(32'h0, 25'd1);
      run_phase(260, 20);
      set_stack_region(32'hFFFF_FFFF, 25'h100_0000);
      run_phase(260, 45);
      set_stack_region($urandom, 25'($urandom_range(1, 25'h100_0000)));
      run_phase(260, 15);
      set_stack_region($urandom, 25'($urandom_range(1, 4096)));
      run_phase(260, 35);

      // Halt: either an undefined call, or everyone exits until nothing runs.
      @(negedge clock);
      if ($urandom_range(1) == 0) begin
         queue_call(make_call(3'($urandom_range(5, 7)), $urandom, $urandom));
      end else begin
         while (!plan.halt) queue_call(make_call(ACT_EXIT, $urandom, $urandom));
      end
      // everything after a halt is ignored, undefined codes included
      repeat (10) queue_call(make_call(3'($urandom_range(7)), $urandom, $urandom));
      wait_idle();

      repeat (64) @(posedge clock);
      if (mismatches == 0 && expected_dispatch.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/prts_pkg.sv
design/prts_if.sv
design/prts_slot_ram.sv
design/process_table_round_robin_scheduler_core.sv
design/prts_checker.sv
tb/tb_top.sv
